// ===== rtl/yc2rgb_pkg.sv =====
// package: coefficients, types and rounding helper for the ycbcr 4:2:2 to rgb converter
package yc2rgb_pkg;

  // unsigned q16 coefficients
  localparam logic [16:0] KY = 17'd76309;

  typedef logic [17:0] coef_t;

  // index 0 is bt.709, index 1 is bt.2020
  localparam coef_t COEF_RV [2] = '{18'd117489, 18'd110014};
  localparam coef_t COEF_GU [2] = '{18'd13975, 18'd12277};
  localparam coef_t COEF_GV [2] = '{18'd34925, 18'd42626};
  localparam coef_t COEF_BU [2] = '{18'd138438, 18'd140363};

  // matrix select codes
  localparam logic MATRIX_BT709  = 1'b0;
  localparam logic MATRIX_BT2020 = 1'b1;

  // offsets of limited-range components
  localparam logic [8:0] LUMA_OFFSET   = 9'd16;
  localparam logic [8:0] CHROMA_OFFSET = 9'd128;

  localparam int ACC_W  = 28;
  localparam int PROD_W = 26;

  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // smallest sum that is clamped to full scale
  localparam acc_t ACC_FULL = acc_t'(255 * 65536);
  localparam acc_t ACC_HALF = acc_t'(32768);

  // clamp to 0..255 and round half up
  function automatic logic [7:0] clamp_round(input acc_t acc);
    acc_t rounded;
    rounded = acc + ACC_HALF;
    if (acc < 0) begin
      clamp_round = 8'd0;
    end else if (acc >= ACC_FULL) begin
      clamp_round = 8'd255;
    end else begin
      clamp_round = rounded[23:16];
    end
  endfunction

endpackage

// ===== rtl/ycbcr422_10bit_to_rgb_core.sv =====
// top level: 10-bit 4:2:2 ycbcr pixel group to two 8-bit rgb pixels
//
// One pixel group (Cb, Y0, Cr, Y1, 10 bits each) is taken on every clock at
// which start is high; busy stays low, so a group can follow in every cycle.
// Each group gives one result, shown on the rgb ports for exactly one cycle
// with done high, after the group has passed the input register and the
// result register. The receiver cannot stall; results leave in order at the
// input rate. The colorimetry write channel is always ready and selects
// bt.709 (0) or bt.2020 (1); write it only while no group is in flight.
module ycbcr422_10bit_to_rgb_core (
  input  logic        clk,
  input  logic        rst,
  // pixel group channel
  input  logic        start,
  output logic        busy,
  input  logic [39:0] pgroup,
  // matrix select register
  input  logic        colorimetry_valid,
  output logic        colorimetry_ready,
  input  logic        colorimetry,
  // result
  output logic        done,
  output logic [7:0]  red_first,
  output logic [7:0]  green_first,
  output logic [7:0]  blue_first,
  output logic [7:0]  red_second,
  output logic [7:0]  green_second,
  output logic [7:0]  blue_second
);

  logic matrix_sel;

  // input stage
  logic       in_vld;
  logic [7:0] cb_q, y0_q, cr_q, y1_q;

  // products
  yc2rgb_pkg::prod_t     py0, py1, prv, pgu, pgv, pbu;
  logic signed [8:0]     yy0, yy1, uu, vv;

  // result sums
  yc2rgb_pkg::acc_t r0_sum, g0_sum, b0_sum, r1_sum, g1_sum, b1_sum;

  assign busy              = 1'b0;
  assign colorimetry_ready = 1'b1;

  // colorimetry register
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_sel <= yc2rgb_pkg::MATRIX_BT709;
    end else if (colorimetry_valid && colorimetry_ready) begin
      matrix_sel <= colorimetry;
    end
  end

  // capture the upper 8 bits of each component
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start && !busy;
    end
    cb_q <= pgroup[39:32];
    y0_q <= pgroup[29:22];
    cr_q <= pgroup[19:12];
    y1_q <= pgroup[9:2];
  end

  // remove offsets and multiply by the matrix coefficients
  always_comb begin
    yy0 = $signed({1'b0, y0_q} - yc2rgb_pkg::LUMA_OFFSET);
    yy1 = $signed({1'b0, y1_q} - yc2rgb_pkg::LUMA_OFFSET);
    uu  = $signed({1'b0, cb_q} - yc2rgb_pkg::CHROMA_OFFSET);
    vv  = $signed({1'b0, cr_q} - yc2rgb_pkg::CHROMA_OFFSET);
    py0 = yc2rgb_pkg::prod_t'(yc2rgb_pkg::KY) * yc2rgb_pkg::prod_t'(yy0);
    py1 = yc2rgb_pkg::prod_t'(yc2rgb_pkg::KY) * yc2rgb_pkg::prod_t'(yy1);
    prv = yc2rgb_pkg::prod_t'(yc2rgb_pkg::COEF_RV[matrix_sel]) *
          yc2rgb_pkg::prod_t'(vv);
    pgu = yc2rgb_pkg::prod_t'(yc2rgb_pkg::COEF_GU[matrix_sel]) *
          yc2rgb_pkg::prod_t'(uu);
    pgv = yc2rgb_pkg::prod_t'(yc2rgb_pkg::COEF_GV[matrix_sel]) *
          yc2rgb_pkg::prod_t'(vv);
    pbu = yc2rgb_pkg::prod_t'(yc2rgb_pkg::COEF_BU[matrix_sel]) *
          yc2rgb_pkg::prod_t'(uu);
  end

  // channel sums, shared chroma terms
  always_comb begin
    r0_sum = yc2rgb_pkg::acc_t'(py0) + yc2rgb_pkg::acc_t'(prv);
    g0_sum = yc2rgb_pkg::acc_t'(py0) - yc2rgb_pkg::acc_t'(pgu) - yc2rgb_pkg::acc_t'(pgv);
    b0_sum = yc2rgb_pkg::acc_t'(py0) + yc2rgb_pkg::acc_t'(pbu);
    r1_sum = yc2rgb_pkg::acc_t'(py1) + yc2rgb_pkg::acc_t'(prv);
    g1_sum = yc2rgb_pkg::acc_t'(py1) - yc2rgb_pkg::acc_t'(pgu) - yc2rgb_pkg::acc_t'(pgv);
    b1_sum = yc2rgb_pkg::acc_t'(py1) + yc2rgb_pkg::acc_t'(pbu);
  end

  // clamp, round and register the result
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_vld;
    end
    red_first    <= yc2rgb_pkg::clamp_round(r0_sum);
    green_first  <= yc2rgb_pkg::clamp_round(g0_sum);
    blue_first   <= yc2rgb_pkg::clamp_round(b0_sum);
    red_second   <= yc2rgb_pkg::clamp_round(r1_sum);
    green_second <= yc2rgb_pkg::clamp_round(g1_sum);
    blue_second  <= yc2rgb_pkg::clamp_round(b1_sum);
  end

endmodule

// ===== rtl/yc2rgb_checker.sv =====
// checker on the converter ports, bound to the top level
module yc2rgb_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [39:0] pgroup,
  input logic        done,
  input logic [7:0]  red_first,
  input logic [7:0]  green_first,
  input logic [7:0]  blue_first,
  input logic [7:0]  red_second,
  input logic [7:0]  green_second,
  input logic [7:0]  blue_second
);

  // every transfer in gives a result after the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 done)
    else $error("missing result after input transfer");

  // no result without a matching input transfer ahead of both registers
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without input transfer");

  // neutral chroma gives gray pixels
  a_gray: assert property (@(posedge clk) disable iff (rst)
    start && !busy && pgroup[39:32] == 8'h80 && pgroup[19:12] == 8'h80 |-> ##2
      (red_first == green_first && green_first == blue_first &&
       red_second == green_second && green_second == blue_second))
    else $error("neutral chroma did not give gray");

  // equal lumas give equal pixels
  a_same_luma: assert property (@(posedge clk) disable iff (rst)
    start && !busy && pgroup[29:22] == pgroup[9:2] |-> ##2
      (red_first == red_second && green_first == green_second &&
       blue_first == blue_second))
    else $error("equal lumas gave different pixels");

endmodule

bind ycbcr422_10bit_to_rgb_core yc2rgb_checker u_yc2rgb_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .pgroup       (pgroup),
  .done         (done),
  .red_first    (red_first),
  .green_first  (green_first),
  .blue_first   (blue_first),
  .red_second   (red_second),
  .green_second (green_second),
  .blue_second  (blue_second)
);

// ===== test/ycbcr422_10bit_to_rgb_core_tb.sv =====
// testbench for the 10-bit 4:2:2 ycbcr pixel group to rgb converter
module ycbcr422_10bit_to_rgb_core_tb;

  localparam int  QUIET_LIMIT  = 2000;
  localparam int  FLUSH_CYCLES = 8;

  // q16 coefficients, index 0 bt.709, index 1 bt.2020
  localparam longint LUMA_GAIN = 76309;
  localparam longint RED_FROM_V [2]   = '{117489, 110014};
  localparam longint GREEN_FROM_U [2] = '{13975, 12277};
  localparam longint GREEN_FROM_V [2] = '{34925, 42626};
  localparam longint BLUE_FROM_U [2]  = '{138438, 140363};
  localparam longint FULL_SCALE_Q16   = 255 * 65536;
  localparam longint HALF_Q16         = 32768;

  typedef struct packed {
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
  } rgb_pair_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [39:0] pgroup = '0;
  logic        colorimetry_valid = 1'b0;
  logic        colorimetry_ready;
  logic        colorimetry = 1'b0;
  logic        done;
  logic [7:0]  red_first;
  logic [7:0]  green_first;
  logic [7:0]  blue_first;
  logic [7:0]  red_second;
  logic [7:0]  green_second;
  logic [7:0]  blue_second;

  // expected rgb pairs, oldest first
  rgb_pair_t pending_rgb[$];
  logic      matrix_sel = yc2rgb_pkg::MATRIX_BT709;
  int        mismatch_count = 0;
  bit        gaps_enabled = 1'b1;

  ycbcr422_10bit_to_rgb_core u_dut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .pgroup            (pgroup),
    .colorimetry_valid (colorimetry_valid),
    .colorimetry_ready (colorimetry_ready),
    .colorimetry       (colorimetry),
    .done              (done),
    .red_first         (red_first),
    .green_first       (green_first),
    .blue_first        (blue_first),
    .red_second        (red_second),
    .green_second      (green_second),
    .blue_second       (blue_second)
  );

  always #2 clk = ~clk;

  // clamp a q16 sum to 0..255 and round half up
  function automatic logic [7:0] saturate_q16(input longint acc);
    longint rounded;
    rounded = (acc + HALF_Q16) >>> 16;
    if (acc < 0) begin
      return 8'd0;
    end else if (acc >= FULL_SCALE_Q16) begin
      return 8'd255;
    end
    return rounded[7:0];
  endfunction

  // one pixel: {r, g, b}
  function automatic logic [23:0] pixel_rgb(input logic [7:0] y, input logic [7:0] cb,
                                            input logic [7:0] cr, input logic matrix);
    longint luma;
    longint u;
    longint v;
    int     m;
    luma = LUMA_GAIN * (longint'(y) - 16);
    u = longint'(cb) - 128;
    v = longint'(cr) - 128;
    m = (matrix == yc2rgb_pkg::MATRIX_BT2020) ? 1 : 0;
    return {saturate_q16(luma + RED_FROM_V[m] * v),
            saturate_q16(luma - GREEN_FROM_U[m] * u - GREEN_FROM_V[m] * v),
            saturate_q16(luma + BLUE_FROM_U[m] * u)};
  endfunction

  // both pixels of a group; the low two bits of each component are dropped
  function automatic rgb_pair_t convert_group(input logic [39:0] pg, input logic matrix);
    logic [7:0] cb;
    logic [7:0] y0;
    logic [7:0] cr;
    logic [7:0] y1;
    cb = pg[39:32];
    y0 = pg[29:22];
    cr = pg[19:12];
    y1 = pg[9:2];
    return {pixel_rgb(y0, cb, cr, matrix), pixel_rgb(y1, cb, cr, matrix)};
  endfunction

  // build a group from 8-bit components plus the discarded low bits
  function automatic logic [39:0] pack_group(input logic [7:0] cb, input logic [7:0] y0,
                                             input logic [7:0] cr, input logic [7:0] y1,
                                             input logic [7:0] low_bits);
    return {cb, low_bits[7:6], y0, low_bits[5:4], cr, low_bits[3:2], y1, low_bits[1:0]};
  endfunction

  function automatic logic [7:0] edge_level();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd16;
      3: return 8'd128;
      4: return 8'd235;
      5: return 8'd240;
      6: return 8'd1;
      default: return 8'd254;
    endcase
  endfunction

  // random group: mostly raw bits, some in video range, some at edge levels
  function automatic logic [39:0] random_group();
    logic [31:0] upper;
    logic [31:0] lower;
    int          mode;
    upper = $urandom();
    lower = $urandom();
    mode = $urandom_range(0, 9);
    if (mode < 5) begin
      return {upper, lower[7:0]};
    end else if (mode < 8) begin
      return pack_group(8'($urandom_range(16, 240)), 8'($urandom_range(16, 235)),
                        8'($urandom_range(16, 240)), 8'($urandom_range(16, 235)),
                        lower[7:0]);
    end
    return pack_group(edge_level(), edge_level(), edge_level(), edge_level(), lower[7:0]);
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_enabled || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  task automatic check_byte(input string field, input logic [7:0] got,
                            input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
    end
  endtask

  // result checker and predictor, sampled at each rising edge
  always @(posedge clk) begin
    rgb_pair_t want;
    if (!rst) begin
      if (done) begin
        if (pending_rgb.size() == 0) begin
          report_mismatch("result with no pixel group outstanding");
        end else begin
          want = pending_rgb.pop_front();
          check_byte("red_first", red_first, want.red_first);
          check_byte("green_first", green_first, want.green_first);
          check_byte("blue_first", blue_first, want.blue_first);
          check_byte("red_second", red_second, want.red_second);
          check_byte("green_second", green_second, want.green_second);
          check_byte("blue_second", blue_second, want.blue_second);
        end
      end
      if (start && !busy) begin
        pending_rgb.push_back(convert_group(pgroup, matrix_sel));
      end
      if (colorimetry_valid && colorimetry_ready) begin
        matrix_sel = colorimetry;
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || done || (colorimetry_valid && colorimetry_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("ycbcr422_10bit_to_rgb_core_tb: FAIL");
    $finish;
  end

  // one pixel group transfer, with a random idle gap ahead of it
  task automatic send_group(input logic [39:0] pg);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    pgroup <= pg;
    do @(posedge clk); while (busy);
  endtask

  // stop sending and wait until every result is back
  task automatic drain_results();
    start <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
  endtask

  // matrix select transfer, only while idle
  task automatic write_matrix(input logic sel);
    drain_results();
    colorimetry_valid <= 1'b1;
    colorimetry       <= sel;
    do @(posedge clk); while (!colorimetry_ready);
    colorimetry_valid <= 1'b0;
  endtask

  // black, white, chroma extremes, luma split and discarded low bits
  task automatic send_directed_set();
    send_group(40'h00_0000_0000);
    send_group(40'hFF_FFFF_FFFF);
    send_group(pack_group(8'd128, 8'd16, 8'd128, 8'd16, 8'h00));
    send_group(pack_group(8'd128, 8'd235, 8'd128, 8'd235, 8'h00));
    send_group(pack_group(8'd128, 8'd255, 8'd128, 8'd255, 8'hFF));
    send_group(pack_group(8'd0, 8'd128, 8'd0, 8'd128, 8'h00));
    send_group(pack_group(8'd255, 8'd128, 8'd255, 8'd128, 8'h00));
    send_group(pack_group(8'd0, 8'd16, 8'd255, 8'd235, 8'h55));
    send_group(pack_group(8'd255, 8'd235, 8'd0, 8'd16, 8'hAA));
    send_group(pack_group(8'd128, 8'd0, 8'd128, 8'd255, 8'h00));
    send_group(pack_group(8'd128, 8'd255, 8'd128, 8'd0, 8'h00));
    send_group(pack_group(8'd90, 8'd81, 8'd240, 8'd145, 8'hFF));
    send_group(pack_group(8'd90, 8'd81, 8'd240, 8'd145, 8'h00));
  endtask

  // directed groups with the matrix left at its reset value
  task automatic test_directed_reset_matrix();
    send_directed_set();
  endtask

  // same groups through the bt.2020 matrix
  task automatic test_directed_bt2020();
    write_matrix(yc2rgb_pkg::MATRIX_BT2020);
    send_directed_set();
  endtask

  // random phases, switching matrix between them, some without gaps
  task automatic test_random_phases();
    logic phase_matrix [6];
    phase_matrix = '{yc2rgb_pkg::MATRIX_BT709, yc2rgb_pkg::MATRIX_BT709,
                     yc2rgb_pkg::MATRIX_BT2020, yc2rgb_pkg::MATRIX_BT2020,
                     yc2rgb_pkg::MATRIX_BT709, yc2rgb_pkg::MATRIX_BT2020};
    for (int phase = 0; phase < 6; phase++) begin
      write_matrix(phase_matrix[phase]);
      gaps_enabled = (phase != 2) && (phase != 4);
      for (int n = 0; n < 300; n++) begin
        send_group(random_group());
        if (phase == 0 && n == 150) begin
          drain_results();
        end
      end
    end
    gaps_enabled = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_reset_matrix();
    test_directed_bt2020();
    test_random_phases();
    drain_results();
    if (pending_rgb.size() != 0) begin
      report_mismatch("pixel groups left without a result");
    end
    if (mismatch_count == 0) begin
      $display("ycbcr422_10bit_to_rgb_core_tb: PASS");
    end else begin
      $display("ycbcr422_10bit_to_rgb_core_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/yc2rgb_pkg.sv
rtl/ycbcr422_10bit_to_rgb_core.sv
rtl/yc2rgb_checker.sv
test/ycbcr422_10bit_to_rgb_core_tb.sv
